>>> sv/glyph_width_and_offset_lookup_top_macros.svh
// Assertion macros for the glyph width and offset lookup block.
`ifndef GLYPH_WIDTH_AND_OFFSET_LOOKUP_TOP_MACROS_SVH
`define GLYPH_WIDTH_AND_OFFSET_LOOKUP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GWOL_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GWOL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GWOL_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define GWOL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> sv/gwol_pkg.sv
// Package with constants for the glyph width and offset lookup block.
package gwol_pkg;

  localparam int MAX_GLYPHS   = 256;
  localparam int HEADER_BYTES = 6;
  localparam int ADDR_W       = $clog2(MAX_GLYPHS);

  localparam logic [7:0] SPACE_CODE          = 8'd32;
  localparam logic [7:0] N_CODE              = 8'd110;
  localparam logic [7:0] SPACE_DEFAULT_WIDTH = 8'd5;

  localparam logic [7:0] CFG_FIRST_CODE  = 8'd0;
  localparam logic [7:0] CFG_GLYPH_COUNT = 8'd1;
  localparam logic [7:0] CFG_PIXEL_ROWS  = 8'd2;
  localparam logic [7:0] CFG_FIXED_MODE  = 8'd3;
  localparam logic [7:0] CFG_FIXED_WIDTH = 8'd4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [7:0] byte_t;

endpackage

>>> sv/glyph_width_and_offset_lookup_top.sv
// Top level of the glyph width and offset lookup block.
// A write item stores one width table entry. A query for a code outside the font goes
// from idle to S_DONE and then to the output register, and a query in fixed-width mode
// passes S_MUL1 and S_MUL2 before S_DONE. A variable-width query passes S_SUM, then S_W,
// S_N when a zero-width space borrows the width of 'n', then S_MUL1 and S_MUL2: the
// bitmap offset sums every earlier entry of the width memory, one read per cycle through
// its single read port. One item is worked on at a time; a finished result waits in the
// output register while the next item is accepted.
`include "glyph_width_and_offset_lookup_top_macros.svh"

module glyph_width_and_offset_lookup_top import gwol_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // entry_index[7:0], entry_width[15:8], code[23:16]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // present[0], glyph_width[8:1], bitmap_offset[24:9], zeros
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_W    = 3'd2;
  localparam logic [2:0] S_N    = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  byte_t       first_code_r, glyph_count_r, pixel_rows_r, fixed_width_r;
  logic        fixed_mode_r;

  logic [2:0]  state_r, state_nxt;
  byte_t       ind_r, ind_nxt;
  byte_t       cnt_r, cnt_nxt;
  byte_t       code_r, code_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        sum_pend_r, sum_pend_nxt;
  byte_t       w_r, w_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic        res_present_r, res_present_nxt;
  byte_t       res_width_r, res_width_nxt;
  logic [15:0] res_off_r, res_off_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  byte_t       mem [MAX_GLYPHS];
  byte_t       rdata_r;
  logic [ADDR_W-1:0] rd_addr;
  logic        wr_en;

  logic        in_acc;
  byte_t       in_index, in_width, in_code;
  logic [8:0]  range_end;
  logic        code_in_font, n_in_font;
  logic [5:0]  bpc;
  logic [15:0] mul_a;
  logic [21:0] mul1;
  logic [23:0] mul2;

  assign in_index  = in_tdata[7:0];
  assign in_width  = in_tdata[15:8];
  assign in_code   = in_tdata[23:16];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign range_end    = {1'b0, first_code_r} + {1'b0, glyph_count_r};
  assign code_in_font = (in_code >= first_code_r) && ({1'b0, in_code} < range_end);
  assign n_in_font    = (N_CODE >= first_code_r) && ({1'b0, N_CODE} < range_end);
  assign bpc          = 6'(({1'b0, pixel_rows_r} + 9'd7) >> 3);
  assign mul_a        = fixed_mode_r ? {8'd0, ind_r} : sum_r;
  assign mul1         = 22'(mul_a) * 22'(bpc);
  assign mul2         = 24'(prod_r) * 24'(w_r);
  assign wr_en        = in_acc && (in_tuser == KIND_WRITE);

  always_comb begin
    rd_addr = ADDR_W'(cnt_r);
    if (state_r == S_W) begin
      rd_addr = ADDR_W'(N_CODE - first_code_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(in_index)] <= in_width;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r  <= 8'd32;
      glyph_count_r <= 8'd96;
      pixel_rows_r  <= 8'd16;
      fixed_mode_r  <= 1'b0;
      fixed_width_r <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_CODE:  first_code_r  <= cfg_data;
        CFG_GLYPH_COUNT: glyph_count_r <= cfg_data;
        CFG_PIXEL_ROWS:  pixel_rows_r  <= cfg_data;
        CFG_FIXED_MODE:  fixed_mode_r  <= cfg_data[0];
        CFG_FIXED_WIDTH: fixed_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    ind_nxt         = ind_r;
    cnt_nxt         = cnt_r;
    code_nxt        = code_r;
    sum_nxt         = sum_r;
    sum_pend_nxt    = 1'b0;
    w_nxt           = w_r;
    prod_nxt        = prod_r;
    res_present_nxt = res_present_r;
    res_width_nxt   = res_width_r;
    res_off_nxt     = res_off_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == KIND_QUERY)) begin
          code_nxt = in_code;
          ind_nxt  = in_code - first_code_r;
          cnt_nxt  = 8'd0;
          sum_nxt  = 16'd0;
          if (!code_in_font) begin
            res_present_nxt = 1'b0;
            res_width_nxt   = 8'd0;
            res_off_nxt     = 16'd0;
            state_nxt       = S_DONE;
          end else if (fixed_mode_r) begin
            w_nxt     = fixed_width_r;
            state_nxt = S_MUL1;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (sum_pend_r) begin
          sum_nxt = sum_r + 16'(rdata_r);
        end
        if (cnt_r != ind_r) begin
          cnt_nxt      = cnt_r + 8'd1;
          sum_pend_nxt = 1'b1;
        end else begin
          state_nxt = S_W;
        end
      end
      S_W: begin
        w_nxt     = rdata_r;
        state_nxt = S_MUL1;
        if ((code_r == SPACE_CODE) && (rdata_r == 8'd0)) begin
          if (n_in_font) begin
            state_nxt = S_N;
          end else begin
            w_nxt = SPACE_DEFAULT_WIDTH;
          end
        end
      end
      S_N: begin
        w_nxt     = rdata_r;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        prod_nxt  = mul1[15:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        res_present_nxt = 1'b1;
        res_width_nxt   = w_r;
        if (fixed_mode_r) begin
          res_off_nxt = mul2[15:0] + 16'(HEADER_BYTES);
        end else begin
          res_off_nxt = prod_r + 16'(glyph_count_r) + 16'(HEADER_BYTES);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, res_off_r, res_width_r, res_present_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_pend_r  <= sum_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ind_r         <= ind_nxt;
    cnt_r         <= cnt_nxt;
    code_r        <= code_nxt;
    sum_r         <= sum_nxt;
    w_r           <= w_nxt;
    prod_r        <= prod_nxt;
    res_present_r <= res_present_nxt;
    res_width_r   <= res_width_nxt;
    res_off_r     <= res_off_nxt;
    out_data_r    <= out_data_nxt;
  end

  `GWOL_ASSERT_NEXT(a_query_leaves_idle, clk, rst_n, in_acc && (in_tuser == KIND_QUERY), state_r != S_IDLE, "query did not start")
  `GWOL_ASSERT_NEXT(a_sum_counts, clk, rst_n, (state_r == S_SUM) && (cnt_r != ind_r), cnt_r == $past(cnt_r) + 8'd1, "summation counter skipped")
  `GWOL_ASSERT_NEXT(a_done_delivers, clk, rst_n, (state_r == S_DONE) && (!out_valid_r || out_tready), out_valid_r && (state_r == S_IDLE), "result not loaded")
  `GWOL_ASSERT_SAME(a_absent_is_zero, clk, rst_n, out_valid_r && !out_data_r[0], out_data_r[24:1] == 24'd0, "absent code with nonzero fields")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the glyph width and offset lookup block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gwol_pkg::*;

  localparam int unsigned LIMIT_CYCLES     = 3000000;
  localparam int unsigned HOLD_AFTER_ITEMS = 700;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned PHASE_ITEMS      = 150;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam logic [7:0]  CFG_UNUSED_LOW   = 8'd5;
  localparam logic [7:0]  CFG_UNUSED_TOP   = 8'd255;

  typedef struct packed {
    logic        present;
    logic [7:0]  width;
    logic [15:0] offset;
  } glyph_result_t;

  class glyph_book;
    byte_t         widths [MAX_GLYPHS];
    int unsigned   first_code, glyph_count, pixel_rows, fixed_mode, fixed_width;
    glyph_result_t pending_lookups [$];
    int unsigned   mismatches, accepted;

    function new();
      first_code  = 32;
      glyph_count = 96;
      pixel_rows  = 16;
      fixed_mode  = 0;
      fixed_width = 5;
      foreach (widths[i]) widths[i] = '0;
      mismatches  = 0;
      accepted    = 0;
    endfunction

    function void set_register(logic [7:0] idx, logic [7:0] data);
      case (idx)
        CFG_FIRST_CODE:  first_code  = data;
        CFG_GLYPH_COUNT: glyph_count = data;
        CFG_PIXEL_ROWS:  pixel_rows  = data;
        CFG_FIXED_MODE:  fixed_mode  = data[0];
        CFG_FIXED_WIDTH: fixed_width = data;
        default: ;
      endcase
    endfunction

    function bit covers(int unsigned c);
      return c >= first_code && c < first_code + glyph_count;
    endfunction

    function glyph_result_t lookup_glyph(int unsigned c);
      glyph_result_t r;
      int unsigned   ind, bytes, w, off, sum, i;
      r = '0;
      if (!covers(c)) return r;
      ind   = c - first_code;
      bytes = (pixel_rows + 7) / 8;
      if (fixed_mode != 0) begin
        w   = fixed_width;
        off = ind * bytes * w + HEADER_BYTES;
      end else begin
        w = widths[ind];
        if (c == SPACE_CODE && w == 0) begin
          if (covers(N_CODE)) w = widths[N_CODE - first_code];
          else w = SPACE_DEFAULT_WIDTH;
        end
        sum = 0;
        for (i = 0; i < ind; i++) sum += widths[i];
        off = sum * bytes + glyph_count + HEADER_BYTES;
      end
      r.present = 1'b1;
      r.width   = w[7:0];
      r.offset  = off[15:0];
      return r;
    endfunction

    function void note_item(logic kind, logic [7:0] idx, logic [7:0] wid, logic [7:0] code);
      accepted++;
      if (kind == KIND_WRITE) widths[idx] = wid;
      else pending_lookups.push_back(lookup_glyph(code));
    endfunction

    function void check_result(logic [31:0] d);
      glyph_result_t got, want;
      got.present = d[0];
      got.width   = d[8:1];
      got.offset  = d[24:9];
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: present=%0d width=%0d offset=%0d",
                   got.present, got.width, got.offset);
        return;
      end
      want = pending_lookups.pop_front();
      if (got.present !== want.present || got.width !== want.width ||
          got.offset !== want.offset) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected present=%0d width=%0d offset=%0d, got %0d %0d %0d",
                   want.present, want.width, want.offset,
                   got.present, got.width, got.offset);
      end
    endfunction

    function int unsigned pending_count();
      return pending_lookups.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  glyph_book   book = new();
  bit          pace_free;
  int unsigned cycles;

  glyph_width_and_offset_lookup_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("glyph_width_and_offset_lookup_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_result(out_tdata);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (pace_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver also holds off once for a long stretch so the block backs up.
  initial begin
    int unsigned stall_left, hold_left, r;
    bit          held;
    out_tready = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && book.accepted >= HOLD_AFTER_ITEMS) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (pace_free) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready <= 1'b1;
        end else if (r < 94) begin
          stall_left = $urandom_range(0, 2);
          out_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(15, 50);
          out_tready <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(logic kind, logic [7:0] idx, logic [7:0] wid, logic [7:0] code);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {code, wid, idx};
    do @(posedge clk); while (!in_tready);
    book.note_item(kind, idx, wid, code);
  endtask

  task automatic query(logic [7:0] code);
    send_item(KIND_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), code);
  endtask

  task automatic write_entry(logic [7:0] idx, logic [7:0] wid);
    send_item(KIND_WRITE, idx, wid, 8'($urandom_range(0, 255)));
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    book.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (book.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_font(logic [7:0] first, logic [7:0] count, logic [7:0] height,
                           logic fixed, logic [7:0] fw);
    settle();
    cfg_write(CFG_FIRST_CODE, first);
    cfg_write(CFG_GLYPH_COUNT, count);
    cfg_write(CFG_PIXEL_ROWS, height);
    cfg_write(CFG_FIXED_MODE, {7'd0, fixed});
    cfg_write(CFG_FIXED_WIDTH, fw);
  endtask

  // Writes stay in the minority; most queries land inside the font range.
  task automatic random_item();
    int unsigned r, top;
    logic [7:0]  idx, wid, code;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      idx = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0 && book.first_code <= SPACE_CODE)
        idx = 8'(SPACE_CODE - book.first_code);
      wid = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      write_entry(idx, wid);
    end else begin
      if (r < 80 && book.glyph_count != 0) begin
        top = book.first_code + book.glyph_count - 1;
        if (top > 255) top = 255;
        code = 8'($urandom_range(top, book.first_code));
      end else if (r < 88) begin
        code = SPACE_CODE;
      end else begin
        code = 8'($urandom_range(0, 255));
      end
      query(code);
    end
  endtask

  initial begin
    int unsigned p, k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pace_free = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every table entry is written before any lookup can read it.
    for (k = 0; k < MAX_GLYPHS; k++)
      write_entry(k[7:0], (k == 0) ? 8'd0 : 8'($urandom_range(0, 255)));

    // Reset font: zero-width space borrows the width of 'n'; range edges.
    query(SPACE_CODE);
    query(8'd31);
    query(8'd127);
    query(8'd128);
    query(8'd0);
    query(8'd255);

    // No 'n' in the font, zero height.
    load_font(8'd0, 8'd100, 8'd0, 1'b0, 8'd5);
    write_entry(SPACE_CODE, 8'd0);
    query(SPACE_CODE);
    query(8'd99);
    query(8'd100);

    // Range that would run past code 255.
    load_font(8'd200, 8'd255, 8'd255, 1'b0, 8'd0);
    query(8'd255);
    query(8'd199);
    query(8'd200);

    // Empty font.
    load_font(8'd0, 8'd0, 8'd8, 1'b0, 8'd5);
    query(8'd0);
    query(8'd255);

    // Fixed width at the extremes, then writes to registers that do not exist.
    load_font(8'd1, 8'd255, 8'd255, 1'b1, 8'd255);
    query(8'd255);
    query(8'd0);
    query(8'd1);
    settle();
    cfg_write(CFG_UNUSED_LOW, 8'($urandom_range(0, 255)));
    cfg_write(CFG_UNUSED_TOP, 8'hFF);
    query(8'd128);

    load_font(8'd10, 8'd200, 8'd9, 1'b1, 8'd0);
    query(8'd128);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_font(8'd0, 8'd255, 8'd255, 1'b0, 8'd255);
        1: load_font(8'd32, 8'd95, 8'd1, 1'b1, 8'd255);
        2: load_font(8'd20, 8'd150, 8'd16, 1'b0, 8'd5);
        default: load_font(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                           8'($urandom_range(0, 255)));
      endcase
      pace_free = (p == 2 || p == 5);
      for (k = 0; k < PHASE_ITEMS; k++) random_item();
      pace_free = 1'b0;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (book.pending_count() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.mismatches == 0 && book.pending_count() == 0) begin
      $display("glyph_width_and_offset_lookup_top regression: pass");
    end else begin
      $display("glyph_width_and_offset_lookup_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/gwol_pkg.sv
sv/glyph_width_and_offset_lookup_top.sv
tb/testbench.sv
